FILE: rtl/prbt_pkg.sv
// prbt_pkg: shared types, widths and codes for the pair ratio band trader
// no dependencies; used by pair_ratio_band_trader_unit
`default_nettype none

package prbt_pkg;

   // sizes
   localparam int MAX_WINDOW_DEFAULT = 32;
   localparam int PRICE_W    = 32;
   localparam int RATIO_W    = 32;
   localparam int MONEY_W    = 48;
   localparam int SQ_W       = 48;
   localparam int WLEN_W     = 6;
   localparam int BAND_W     = 4;
   localparam int BAND_SQ_W  = 8;
   localparam int POS_W      = 2;
   localparam int FRAC_W     = 24;
   localparam int SQ_SHIFT   = 16;
   localparam int DIV_W      = 64;
   localparam int DIV_CNT_W  = 6;
   localparam int QUO24_W    = 56;
   localparam int FACTOR_W   = 58;
   localparam int MUL_W      = 112;
   localparam int MPLIER_W   = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // reset values and fixed numbers
   localparam logic [WLEN_W-1:0]  WINDOW_LENGTH_RESET = 6'd30;
   localparam logic [BAND_W-1:0]  BAND_FACTOR_RESET   = 4'd2;
   localparam logic [MONEY_W-1:0] INITIAL_MONEY_RESET = 48'd16777216000;
   localparam logic [WLEN_W-1:0]  MIN_WINDOW          = 6'd2;
   localparam logic [MONEY_W-1:0] MONEY_MAX           = '1;
   localparam logic [QUO24_W-1:0] ONE_Q24             = 56'h1000000;

   // position codes
   localparam logic [POS_W-1:0] POS_FLAT  = 2'd0;
   localparam logic [POS_W-1:0] POS_LONG  = 2'd1;
   localparam logic [POS_W-1:0] POS_SHORT = 2'd2;

   // register indexes, taken from paddr[4:3]
   typedef enum logic [1:0] {
      REG_WINDOW_LENGTH = 2'd0,
      REG_BAND_FACTOR   = 2'd1,
      REG_INITIAL_MONEY = 2'd2
   } csr_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_R,
      S_MUL_RSQ,
      S_FILL,
      S_DIV_A,
      S_DIV_B,
      S_FACTOR,
      S_MUL_ACC,
      S_DIV_MEAN,
      S_DIV_VAR,
      S_MUL_M2,
      S_MUL_DEV,
      S_MUL_BAND,
      S_MUL_OLD,
      S_UPDATE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [PRICE_W-1:0] first_price;
      logic [PRICE_W-1:0] second_price;
      logic               series_start;
   } req_payload_type;

   typedef struct packed {
      logic [MONEY_W-1:0] account_out;
      logic [POS_W-1:0]   position_out;
      logic               warming_up;
      logic               price_error;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: rtl/prbt_ram.sv
// prbt_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module prbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/pair_ratio_band_trader_unit.sv
// pair_ratio_band_trader_unit: rolling ratio band pairs trader, top level
// depends on prbt_pkg and prbt_ram
//
//   channel | direction | handshake                 | payload
//   req     | in        | req_valid / req_stall     | req_data  (prbt_pkg::req_payload_type)
//   rsp     | out       | rsp_valid / rsp_stall     | rsp_data  (prbt_pkg::rsp_payload_type)
//   csr     | in/out    | csr_psel/penable, pready  | paddr, pwdata, prdata (64 bit)
//
// one transaction at a time; a shared bit-serial divider (64 steps per quotient)
// and a shift-add multiplier (one multiplier bit per cycle) do all arithmetic
// a trading day's time goes mostly to its five quotients; a warm-up day needs
// one quotient and a zero-price day none
// reset is synchronous active high and needs no clearing pass
// req_stall is high while a transaction is worked on; a finished result waits
// in the output register while the next transaction is taken
`default_nettype none

module pair_ratio_band_trader_unit #(
   parameter int MAX_WINDOW = prbt_pkg::MAX_WINDOW_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire prbt_pkg::req_payload_type            req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output prbt_pkg::rsp_payload_type                 rsp_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [prbt_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [prbt_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [prbt_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                      csr_pready
);

   localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
   localparam int FILL_W  = LEN_W + 1;
   localparam int SUM_W   = prbt_pkg::RATIO_W + IDX_W;
   localparam int SQSUM_W = prbt_pkg::SQ_W + IDX_W;
   localparam int RW      = prbt_pkg::RATIO_W;
   localparam int MW      = prbt_pkg::MONEY_W;
   localparam int SW      = prbt_pkg::SQ_W;
   localparam int QW      = prbt_pkg::QUO24_W;
   localparam int FW      = prbt_pkg::FACTOR_W;

   // sequencer and configuration
   prbt_pkg::state_type state_ff, state_in;
   logic issued_ff, issued_in;
   logic [prbt_pkg::WLEN_W-1:0] wl_ff, wl_in;
   logic [prbt_pkg::BAND_W-1:0] bf_ff, bf_in;
   logic [MW-1:0] im_ff, im_in;

   // architectural state
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SQSUM_W-1:0] sqsum_ff, sqsum_in;
   logic [LEN_W-1:0] days_ff, days_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [prbt_pkg::PRICE_W-1:0] prev1_ff, prev1_in, prev2_ff, prev2_in;
   logic [MW-1:0] acc_ff, acc_in;
   logic [prbt_pkg::POS_W-1:0] pos_ff, pos_in;

   // per-transaction working registers
   prbt_pkg::req_payload_type in_ff, in_in;
   logic err_ff, err_in, warm_ff, warm_in;
   logic [RW-1:0] r_ff, r_in, mean_ff, mean_in, dev_ff, dev_in;
   logic [SW-1:0] rsq_ff, rsq_in, varhi_ff, varhi_in, var_ff, var_in;
   logic [SW-1:0] dev2_ff, dev2_in, oldsq_ff, oldsq_in;
   logic [QW-1:0] a_ff, a_in, b_ff, b_in;
   logic [FW-2:0] fac_ff, fac_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   prbt_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // shared divider
   logic div_start;
   logic [prbt_pkg::DIV_W-1:0] div_dividend;
   logic [RW-1:0] div_divisor;
   logic div_run_ff, div_run_in;
   logic [prbt_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [RW-1:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [prbt_pkg::DIV_W-1:0] div_quo_ff, div_quo_in;
   logic [RW:0] div_trial, div_diff;
   logic div_fits;

   // shared multiplier
   logic mul_start;
   logic [prbt_pkg::MUL_W-1:0] mul_mcand;
   logic [prbt_pkg::MPLIER_W-1:0] mul_mplier;
   logic mul_run_ff, mul_run_in;
   logic [prbt_pkg::MUL_W-1:0] mul_prod_ff, mul_prod_in, mul_mcand_ff, mul_mcand_in;
   logic [prbt_pkg::MPLIER_W-1:0] mul_mplier_ff, mul_mplier_in;

   // window memory
   logic ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [RW-1:0] ram_rdata;

   // misc combinational
   logic [LEN_W-1:0] eff_len;
   logic [FILL_W-1:0] fill_sum;
   logic [IDX_W-1:0] fill_addr;
   logic signed [FW-1:0] fac_long, fac_short, fac_sel;
   logic [SW-1:0] m2;
   logic [prbt_pkg::BAND_SQ_W-1:0] band_sq;
   logic csr_write;
   logic req_accept;
   logic [LEN_W-1:0] days_eff;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != prbt_pkg::S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign band_sq    = prbt_pkg::BAND_SQ_W'(bf_ff) * prbt_pkg::BAND_SQ_W'(bf_ff);

   // effective window length, clamped to [2, MAX_WINDOW]
   always_comb begin
      if (32'(wl_ff) > 32'(MAX_WINDOW)) begin
         eff_len = LEN_W'(MAX_WINDOW);
      end else if (wl_ff < prbt_pkg::MIN_WINDOW) begin
         eff_len = LEN_W'(prbt_pkg::MIN_WINDOW);
      end else begin
         eff_len = LEN_W'(wl_ff);
      end
   end

   // slot for the next ratio while the window fills
   always_comb begin
      fill_sum = FILL_W'(head_ff) + FILL_W'(days_ff);
      if (fill_sum >= FILL_W'(eff_len)) begin
         fill_sum = fill_sum - FILL_W'(eff_len);
      end
      fill_addr = IDX_W'(fill_sum);
   end

   // account factors for both positions
   always_comb begin
      fac_long  = $signed({2'b00, prbt_pkg::ONE_Q24}) + $signed({2'b00, a_ff})
                  - $signed({2'b00, b_ff});
      fac_short = $signed({2'b00, prbt_pkg::ONE_Q24}) - $signed({2'b00, a_ff})
                  + $signed({2'b00, b_ff});
      fac_sel   = (pos_ff == prbt_pkg::POS_LONG) ? fac_long : fac_short;
      m2        = mul_prod_ff[SW+prbt_pkg::SQ_SHIFT-1:prbt_pkg::SQ_SHIFT];
   end

   // register reads
   always_comb begin
      case (prbt_pkg::csr_index_type'(csr_paddr[4:3]))
         prbt_pkg::REG_WINDOW_LENGTH: csr_prdata = prbt_pkg::CSR_DATA_W'(wl_ff);
         prbt_pkg::REG_BAND_FACTOR:   csr_prdata = prbt_pkg::CSR_DATA_W'(bf_ff);
         prbt_pkg::REG_INITIAL_MONEY: csr_prdata = prbt_pkg::CSR_DATA_W'(im_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // divider: restoring, one quotient bit per cycle
   always_comb begin
      div_trial  = {div_rem_ff, div_quo_ff[prbt_pkg::DIV_W-1]};
      div_diff   = div_trial - {1'b0, div_den_ff};
      div_fits   = (div_trial >= {1'b0, div_den_ff});
      div_run_in = div_run_ff;
      div_cnt_in = div_cnt_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_den_in = div_den_ff;
      if (div_start) begin
         div_run_in = 1'b1;
         div_cnt_in = '0;
         div_rem_in = '0;
         div_quo_in = div_dividend;
         div_den_in = div_divisor;
      end else if (div_run_ff) begin
         div_rem_in = div_fits ? div_diff[RW-1:0] : div_trial[RW-1:0];
         div_quo_in = {div_quo_ff[prbt_pkg::DIV_W-2:0], div_fits};
         div_cnt_in = div_cnt_ff + 1'b1;
         if (div_cnt_ff == '1) begin
            div_run_in = 1'b0;
         end
      end
   end

   // multiplier: shift-add over multiplier bits, stops when none are left
   always_comb begin
      mul_run_in    = mul_run_ff;
      mul_prod_in   = mul_prod_ff;
      mul_mcand_in  = mul_mcand_ff;
      mul_mplier_in = mul_mplier_ff;
      if (mul_start) begin
         mul_run_in    = (mul_mplier != '0);
         mul_prod_in   = '0;
         mul_mcand_in  = mul_mcand;
         mul_mplier_in = mul_mplier;
      end else if (mul_run_ff) begin
         if (mul_mplier_ff[0]) begin
            mul_prod_in = mul_prod_ff + mul_mcand_ff;
         end
         mul_mcand_in  = mul_mcand_ff << 1;
         mul_mplier_in = mul_mplier_ff >> 1;
         mul_run_in    = (mul_mplier_ff[prbt_pkg::MPLIER_W-1:1] != '0);
      end
   end

   // sequencer: next state, unit control and state updates
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      wl_in        = wl_ff;
      bf_in        = bf_ff;
      im_in        = im_ff;
      sum_in       = sum_ff;
      sqsum_in     = sqsum_ff;
      days_in      = days_ff;
      head_in      = head_ff;
      prev1_in     = prev1_ff;
      prev2_in     = prev2_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      in_in        = in_ff;
      err_in       = err_ff;
      warm_in      = warm_ff;
      r_in         = r_ff;
      rsq_in       = rsq_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      fac_in       = fac_ff;
      mean_in      = mean_ff;
      varhi_in     = varhi_ff;
      var_in       = var_ff;
      dev_in       = dev_ff;
      dev2_in      = dev2_ff;
      oldsq_in     = oldsq_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      mul_start    = 1'b0;
      mul_mcand    = '0;
      mul_mplier   = '0;
      ram_we       = 1'b0;
      ram_waddr    = head_ff;
      days_eff     = days_ff;

      case (state_ff)
         prbt_pkg::S_IDLE: begin
            if (req_valid) begin
               in_in = req_data;
               if (req_data.series_start) begin
                  sum_in   = '0;
                  sqsum_in = '0;
                  days_in  = '0;
                  head_in  = '0;
                  prev1_in = '0;
                  prev2_in = '0;
                  acc_in   = im_ff;
                  pos_in   = prbt_pkg::POS_LONG;
                  days_eff = '0;
               end
               warm_in = (days_eff < eff_len);
               err_in  = (req_data.first_price == '0) || (req_data.second_price == '0);
               state_in = err_in ? prbt_pkg::S_DONE : prbt_pkg::S_DIV_R;
            end
         end

         // today's ratio, saturated to 32 bits
         prbt_pkg::S_DIV_R: begin
            div_dividend = prbt_pkg::DIV_W'({in_ff.first_price, 24'b0});
            div_divisor  = in_ff.second_price;
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (!div_run_ff) begin
               issued_in = 1'b0;
               r_in = (div_quo_ff[prbt_pkg::DIV_W-1:RW] != '0) ? '1 : div_quo_ff[RW-1:0];
               state_in = prbt_pkg::S_MUL_RSQ;
            end
         end

         prbt_pkg::S_MUL_RSQ: begin
            mul_mcand  = prbt_pkg::MUL_W'(r_ff);
            mul_mplier = prbt_pkg::MPLIER_W'(r_ff);
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (!mul_run_ff) begin
               issued_in = 1'b0;
               rsq_in    = m2;
               state_in  = (days_ff < eff_len) ? prbt_pkg::S_FILL : prbt_pkg::S_DIV_A;
            end
         end

         // window still filling
         prbt_pkg::S_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = fill_addr;
            sum_in    = sum_ff + SUM_W'(r_ff);
            sqsum_in  = sqsum_ff + SQSUM_W'(rsq_ff);
            days_in   = days_ff + 1'b1;
            prev1_in  = in_ff.first_price;
            prev2_in  = in_ff.second_price;
            state_in  = prbt_pkg::S_DONE;
         end

         // price return of the first asset
         prbt_pkg::S_DIV_A: begin
            div_dividend = prbt_pkg::DIV_W'({in_ff.first_price, 24'b0});
            div_divisor  = prev1_ff;
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (!div_run_ff) begin
               issued_in = 1'b0;
               a_in = (prev1_ff == '0) ? prbt_pkg::ONE_Q24 : div_quo_ff[QW-1:0];
               state_in = prbt_pkg::S_DIV_B;
            end
         end

         // price return of the second asset
         prbt_pkg::S_DIV_B: begin
            div_dividend = prbt_pkg::DIV_W'({in_ff.second_price, 24'b0});
            div_divisor  = prev2_ff;
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (!div_run_ff) begin
               issued_in = 1'b0;
               b_in = (prev2_ff == '0) ? prbt_pkg::ONE_Q24 : div_quo_ff[QW-1:0];
               state_in = prbt_pkg::S_FACTOR;
            end
         end

         // flat keeps the account, a factor at or below zero wipes it
         prbt_pkg::S_FACTOR: begin
            fac_in   = fac_sel[FW-2:0];
            state_in = prbt_pkg::S_DIV_MEAN;
            if (pos_ff == prbt_pkg::POS_LONG || pos_ff == prbt_pkg::POS_SHORT) begin
               if (fac_sel[FW-1] || fac_sel == '0 || acc_ff == '0) begin
                  acc_in = '0;
               end else begin
                  state_in = prbt_pkg::S_MUL_ACC;
               end
            end
         end

         prbt_pkg::S_MUL_ACC: begin
            mul_mcand  = prbt_pkg::MUL_W'(acc_ff);
            mul_mplier = prbt_pkg::MPLIER_W'(fac_ff);
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (!mul_run_ff) begin
               issued_in = 1'b0;
               if (mul_prod_ff[prbt_pkg::MUL_W-1:prbt_pkg::FRAC_W+MW] != '0) begin
                  acc_in = prbt_pkg::MONEY_MAX;
               end else begin
                  acc_in = mul_prod_ff[prbt_pkg::FRAC_W+MW-1:prbt_pkg::FRAC_W];
               end
               state_in = prbt_pkg::S_DIV_MEAN;
            end
         end

         prbt_pkg::S_DIV_MEAN: begin
            div_dividend = prbt_pkg::DIV_W'(sum_ff);
            div_divisor  = RW'(eff_len);
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (!div_run_ff) begin
               issued_in = 1'b0;
               mean_in   = div_quo_ff[RW-1:0];
               state_in  = prbt_pkg::S_DIV_VAR;
            end
         end

         prbt_pkg::S_DIV_VAR: begin
            div_dividend = prbt_pkg::DIV_W'(sqsum_ff);
            div_divisor  = RW'(eff_len);
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (!div_run_ff) begin
               issued_in = 1'b0;
               varhi_in  = div_quo_ff[SW-1:0];
               state_in  = prbt_pkg::S_MUL_M2;
            end
         end

         // variance clamped at zero, distance from the mean
         prbt_pkg::S_MUL_M2: begin
            mul_mcand  = prbt_pkg::MUL_W'(mean_ff);
            mul_mplier = prbt_pkg::MPLIER_W'(mean_ff);
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (!mul_run_ff) begin
               issued_in = 1'b0;
               var_in    = (varhi_ff > m2) ? (varhi_ff - m2) : '0;
               dev_in    = (r_ff > mean_ff) ? (r_ff - mean_ff) : (mean_ff - r_ff);
               state_in  = prbt_pkg::S_MUL_DEV;
            end
         end

         prbt_pkg::S_MUL_DEV: begin
            mul_mcand  = prbt_pkg::MUL_W'(dev_ff);
            mul_mplier = prbt_pkg::MPLIER_W'(dev_ff);
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (!mul_run_ff) begin
               issued_in = 1'b0;
               dev2_in   = m2;
               state_in  = prbt_pkg::S_MUL_BAND;
            end
         end

         // band test and new position
         prbt_pkg::S_MUL_BAND: begin
            mul_mcand  = prbt_pkg::MUL_W'(var_ff);
            mul_mplier = prbt_pkg::MPLIER_W'(band_sq);
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (!mul_run_ff) begin
               issued_in = 1'b0;
               if (QW'(dev2_ff) <= mul_prod_ff[QW-1:0]) begin
                  pos_in = prbt_pkg::POS_FLAT;
               end else if (r_ff < mean_ff) begin
                  pos_in = prbt_pkg::POS_LONG;
               end else begin
                  pos_in = prbt_pkg::POS_SHORT;
               end
               state_in = prbt_pkg::S_MUL_OLD;
            end
         end

         // square of the ratio leaving the window
         prbt_pkg::S_MUL_OLD: begin
            mul_mcand  = prbt_pkg::MUL_W'(ram_rdata);
            mul_mplier = prbt_pkg::MPLIER_W'(ram_rdata);
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (!mul_run_ff) begin
               issued_in = 1'b0;
               oldsq_in  = m2;
               state_in  = prbt_pkg::S_UPDATE;
            end
         end

         // slide the window
         prbt_pkg::S_UPDATE: begin
            ram_we   = 1'b1;
            sum_in   = sum_ff - SUM_W'(ram_rdata) + SUM_W'(r_ff);
            sqsum_in = sqsum_ff - SQSUM_W'(oldsq_ff) + SQSUM_W'(rsq_ff);
            if ((LEN_W'(head_ff) + LEN_W'(1)) == eff_len) begin
               head_in = '0;
            end else begin
               head_in = head_ff + IDX_W'(1);
            end
            prev1_in = in_ff.first_price;
            prev2_in = in_ff.second_price;
            state_in = prbt_pkg::S_DONE;
         end

         // hand the result to the output register once it is free
         prbt_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.account_out  = acc_ff;
               rsp_data_in.position_out = pos_ff;
               rsp_data_in.warming_up   = warm_ff;
               rsp_data_in.price_error  = err_ff;
               state_in                 = prbt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in  = prbt_pkg::S_IDLE;
            issued_in = 1'b0;
         end
      endcase

      // register writes
      if (csr_write) begin
         case (prbt_pkg::csr_index_type'(csr_paddr[4:3]))
            prbt_pkg::REG_WINDOW_LENGTH: begin
               wl_in    = csr_pwdata[prbt_pkg::WLEN_W-1:0];
               sum_in   = '0;
               sqsum_in = '0;
               days_in  = '0;
               head_in  = '0;
            end
            prbt_pkg::REG_BAND_FACTOR:   bf_in = csr_pwdata[prbt_pkg::BAND_W-1:0];
            prbt_pkg::REG_INITIAL_MONEY: im_in = csr_pwdata[MW-1:0];
            default: begin
               wl_in = wl_ff;
            end
         endcase
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prbt_pkg::S_IDLE;
         issued_ff    <= 1'b0;
         wl_ff        <= prbt_pkg::WINDOW_LENGTH_RESET;
         bf_ff        <= prbt_pkg::BAND_FACTOR_RESET;
         im_ff        <= prbt_pkg::INITIAL_MONEY_RESET;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         days_ff      <= '0;
         head_ff      <= '0;
         prev1_ff     <= '0;
         prev2_ff     <= '0;
         acc_ff       <= prbt_pkg::INITIAL_MONEY_RESET;
         pos_ff       <= prbt_pkg::POS_LONG;
         rsp_valid_ff <= 1'b0;
         div_run_ff   <= 1'b0;
         mul_run_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         wl_ff        <= wl_in;
         bf_ff        <= bf_in;
         im_ff        <= im_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         days_ff      <= days_in;
         head_ff      <= head_in;
         prev1_ff     <= prev1_in;
         prev2_ff     <= prev2_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         div_run_ff   <= div_run_in;
         mul_run_ff   <= mul_run_in;
      end
   end

   // working registers and unit datapaths
   always_ff @(posedge clock) begin
      in_ff         <= in_in;
      err_ff        <= err_in;
      warm_ff       <= warm_in;
      r_ff          <= r_in;
      rsq_ff        <= rsq_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      fac_ff        <= fac_in;
      mean_ff       <= mean_in;
      varhi_ff      <= varhi_in;
      var_ff        <= var_in;
      dev_ff        <= dev_in;
      dev2_ff       <= dev2_in;
      oldsq_ff      <= oldsq_in;
      rsp_data_ff   <= rsp_data_in;
      div_cnt_ff    <= div_cnt_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_den_ff    <= div_den_in;
      mul_prod_ff   <= mul_prod_in;
      mul_mcand_ff  <= mul_mcand_in;
      mul_mplier_ff <= mul_mplier_in;
   end

   // ratio window, read port parked on the oldest entry
   prbt_ram #(
      .WIDTH(RW),
      .DEPTH(MAX_WINDOW)
   ) u_window (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(r_ff),
      .rd_addr(head_ff),
      .rd_data(ram_rdata)
   );

`ifndef ASSERT_OFF
   a_head_in_window: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(head_ff) < eff_len)
      else $error("window head beyond window length");

   a_days_bounded: assert property (@(posedge clock) disable iff (reset)
      days_ff <= eff_len)
      else $error("fill count beyond window length");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != prbt_pkg::S_IDLE)
      else $error("accepted transaction not worked on");

   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_run_ff)
      else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire
